// ===== hw/rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Types and codes for the partitioned multi-queue: beat structs, operation
// and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package pmq_pkg;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_op                op;
        logic        [2:0]  queue_num;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data_out;
    } t_out_beat;

endpackage

// ===== hw/rtl/partitioned_multi_queue.sv =====
// ----------------------------------------------------------------------------
// partitioned_multi_queue
// Several linear queues sharing one data memory, cut into equal partitions.
// Enqueue and dequeue beats in, one status beat out per operation.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_beat  (t_in_beat)
//  out      | output    | o_out_valid / i_out_ready  | o_out_beat (t_out_beat)
//
//  An enqueue, a rejected operation or an empty dequeue goes straight to the
//  result register; a successful dequeue first reads the data memory and loads
//  the result in S_READ. Pointers and occupancy sit in flops beside the memory.
//  Reset is synchronous and clears pointers and occupancy, not the data memory.
//  Input is held off in S_READ or while the result register is full and not taken.
// ----------------------------------------------------------------------------
module partitioned_multi_queue
    import pmq_pkg::*;
#(
    parameter int NUM_QUEUES      = 4,
    parameter int SLOTS_PER_QUEUE = 8,
    parameter int DATA_WIDTH      = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam int TOTAL_SLOTS = NUM_QUEUES * SLOTS_PER_QUEUE;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int OW = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
    localparam int AW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam logic [OW-1:0] LAST_SLOT = OW'(SLOTS_PER_QUEUE - 1);

    // pointer state, one entry per queue
    logic [OW-1:0] r_front [NUM_QUEUES];
    logic [OW-1:0] r_rear  [NUM_QUEUES];
    logic          r_occ   [NUM_QUEUES];

    // shared data memory
    logic [DATA_WIDTH-1:0] r_mem [TOTAL_SLOTS];
    logic [DATA_WIDTH-1:0] r_rd_data;

    t_state    r_state, n_state;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out_beat, n_out_beat;

    logic            in_acc;
    logic            q_ok;
    logic [QW-1:0]   q_idx;
    logic [OW-1:0]   cur_front, cur_rear;
    logic            cur_occ;
    logic            ptr_we;
    logic [OW-1:0]   n_front, n_rear;
    logic            n_occ;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_addr;
    logic [OW-1:0]   slot;
    logic [63:0]     in_ext;
    logic [31:0]     rd_ext;

    assign q_ok      = 4'(i_in_beat.queue_num) < 4'(NUM_QUEUES);
    assign q_idx     = QW'(i_in_beat.queue_num);
    assign cur_front = r_front[q_idx];
    assign cur_rear  = r_rear[q_idx];
    assign cur_occ   = r_occ[q_idx];
    assign mem_addr  = AW'(int'(q_idx) * SLOTS_PER_QUEUE + int'(slot));
    assign in_ext    = {32'd0, i_in_beat.value};
    assign rd_ext    = 32'(r_rd_data);

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        ptr_we      = 1'b0;
        n_front     = cur_front;
        n_rear      = cur_rear;
        n_occ       = cur_occ;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        slot        = cur_front;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_valid         = 1'b1;
                    n_out_beat.status   = ST_OK;
                    n_out_beat.data_out = '0;
                    if (!q_ok) begin
                        n_out_beat.status = ST_INVALID;
                    end else if (i_in_beat.op == OP_ENQ) begin
                        if (cur_occ && cur_rear == LAST_SLOT) begin
                            n_out_beat.status = ST_FULL;
                        end else begin
                            ptr_we = 1'b1;
                            mem_we = 1'b1;
                            n_occ  = 1'b1;
                            if (!cur_occ) begin
                                n_front = '0;
                                n_rear  = '0;
                            end else begin
                                n_rear = cur_rear + 1'b1;
                            end
                            slot = n_rear;
                        end
                    end else if (!cur_occ) begin
                        n_out_beat.status = ST_EMPTY;
                    end else begin
                        // read the front word; result follows once the memory returns it
                        ptr_we      = 1'b1;
                        mem_re      = 1'b1;
                        slot        = cur_front;
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                        if (cur_front == cur_rear) begin
                            n_occ   = 1'b0;
                            n_front = '0;
                            n_rear  = '0;
                        end else begin
                            n_front = cur_front + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid         = 1'b1;
                n_out_beat.status   = ST_OK;
                n_out_beat.data_out = rd_ext;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_front[i] <= '0;
                r_rear[i]  <= '0;
                r_occ[i]   <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (ptr_we) begin
                r_front[q_idx] <= n_front;
                r_rear[q_idx]  <= n_rear;
                r_occ[q_idx]   <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= DATA_WIDTH'(in_ext);
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // the result register is always free while a read is in flight
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result register busy during memory read");

    a_deq_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && q_ok && i_in_beat.op == OP_DEQ && cur_occ) |=> (r_state == S_READ))
        else $error("dequeue did not start a memory read");

    a_drained_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_occ[0] |-> (r_front[0] == '0 && r_rear[0] == '0))
        else $error("empty queue with pointers away from partition start");

    a_front_behind_rear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ[0] |-> (r_front[0] <= r_rear[0]))
        else $error("front passed rear");

    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !in_acc)
        else $error("beat accepted during memory read");

endmodule
